// ===== src/pps_pkg.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared constants, codes and types for the scheduler cells and controller.
// ---------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CntW     = SlotW + 1;
  localparam int TimeW    = 16;
  localparam int IdW      = 8;
  localparam int PrioW    = 8;
  localparam int BurstW   = 16;
  localparam int SwTimeW  = 8;
  localparam int CountW   = 16;
  localparam int InDataW  = 56;
  localparam int OutDataW = 80;

  localparam logic CfgSwitchTime = 1'b0;
  localparam logic CfgTaskCount  = 1'b1;

  localparam logic InKindLoad = 1'b0;
  localparam logic InKindTick = 1'b1;

  localparam logic [1:0] ActIdle   = 2'd0;
  localparam logic [1:0] ActSwitch = 2'd1;
  localparam logic [1:0] ActRan    = 2'd2;
  localparam logic [1:0] ActNone   = 2'd3;

  typedef struct packed {
    logic              live;
    logic              found;
    logic [PrioW-1:0]  prio;
    logic [IdW-1:0]    id;
    logic [SlotW-1:0]  slot;
  } pps_token_t;

  typedef struct packed {
    logic              load_we;
    logic [SlotW-1:0]  load_slot;
    logic [IdW-1:0]    load_id;
    logic [TimeW-1:0]  load_arrival;
    logic [BurstW-1:0] load_burst;
    logic [PrioW-1:0]  load_prio;
    logic              dec_we;
    logic [SlotW-1:0]  dec_slot;
    logic [CntW-1:0]   cnt;
    logic [TimeW-1:0]  now;
  } pps_bcast_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == {CountW{1'b1}}) ? v : v + CountW'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/preemptive_priority_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler
// Each tick transaction advances simulated time one unit; load transactions
// fill task slots. The input channel carries a load or tick kind in tuser and
// the slot contents in tdata. Every input transaction yields exactly one
// output transaction: activity in tuser, time, task id, finish flag and time,
// the all-done flag and the switch counters in tdata.
// A load goes from acceptance straight to the output register fill. A tick
// that needs a selection passes a prep step that starts the best-candidate
// token, a walk of the token through the row of task cells, a decision step,
// an update step that applies the decision when a task runs, and the output
// register fill; an idle tick or one that starts a switch skips the update.
// A tick that only counts down a context switch goes from prep to the fill;
// one that starts the held task goes from prep through update to the fill.
// One transaction is processed at a time; the next one is accepted once the
// result sits in the output register, so one waiting result does not stall
// the input. If the receiver stalls with a result waiting, the next result
// is held until the output register frees.
// Reset clears remaining times, time, counters and configuration; no
// clearing pass is needed. Configuration writes take effect at once.
// ---------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler_top
  import pps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [SwTimeW-1:0]  cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tuser: kind
  input  wire logic [0:0]          s_axis_tuser,
  // tdata: slot, task_id, arrival, burst, priority_req, zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tuser: activity
  output logic [1:0]               m_axis_tuser,
  // tdata: tick_time, ran_id, finished, finish_time, all_done, switch_count,
  // switch_ticks, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata
);

  pps_bcast_t          bc;
  pps_token_t          tok [MaxTasks+1];
  logic [MaxTasks-1:0] nz;
  logic [MaxTasks-1:0] one;

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_kind_i    (s_axis_tuser[0]),
    .s_data_i    (s_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_user_o    (m_axis_tuser),
    .m_data_o    (m_axis_tdata),
    .bc_o        (bc),
    .tok_start_o (tok[0]),
    .tok_end_i   (tok[MaxTasks]),
    .nz_i        (nz),
    .one_i       (one)
  );

  for (genvar k = 0; k < MaxTasks; k++) begin : g_cell
    pps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SlotW'(k)),
      .bc_i   (bc),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .nz_o   (nz[k]),
      .one_o  (one[k])
    );
  end

endmodule

`default_nettype wire

// ===== src/pps_cell.sv =====
// ---------------------------------------------------------------------------
// Scheduler task cell
// Holds one task slot and passes the best-candidate token to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_cell
  import pps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SlotW-1:0] idx_i,
  input  wire pps_bcast_t       bc_i,
  input  wire pps_token_t       tok_i,
  output pps_token_t            tok_o,
  output logic                  nz_o,
  output logic                  one_o
);

  logic [IdW-1:0]    id_q;
  logic [TimeW-1:0]  arr_q;
  logic [PrioW-1:0]  prio_q;
  logic [BurstW-1:0] rem_q, rem_d;
  pps_token_t        tok_q, tok_d;
  logic              ready;
  logic              better;

  assign ready  = ({1'b0, idx_i} < bc_i.cnt) && (rem_q != '0) && (arr_q <= bc_i.now);
  assign better = !tok_i.found || (prio_q < tok_i.prio) ||
                  ((prio_q == tok_i.prio) && (id_q < tok_i.id));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.live && ready && better) begin
      tok_d.found = 1'b1;
      tok_d.prio  = prio_q;
      tok_d.id    = id_q;
      tok_d.slot  = idx_i;
    end
    rem_d = rem_q;
    if (bc_i.load_we && (bc_i.load_slot == idx_i)) begin
      rem_d = bc_i.load_burst;
    end else if (bc_i.dec_we && (bc_i.dec_slot == idx_i)) begin
      rem_d = rem_q - BurstW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      tok_q <= '0;
    end else begin
      rem_q <= rem_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.load_we && (bc_i.load_slot == idx_i)) begin
      id_q   <= bc_i.load_id;
      arr_q  <= bc_i.load_arrival;
      prio_q <= bc_i.load_prio;
    end
  end

  assign tok_o = tok_q;
  assign nz_o  = (rem_q != '0);
  assign one_o = (rem_q == BurstW'(1));

endmodule

`default_nettype wire

// ===== src/pps_ctrl.sv =====
// ---------------------------------------------------------------------------
// Scheduler controller
// Sequences load and tick transactions, keeps time, switch state and counters.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [SwTimeW-1:0]  cfg_data_i,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire logic                s_kind_i,
  input  wire logic [InDataW-1:0]  s_data_i,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output logic [1:0]               m_user_o,
  output logic [OutDataW-1:0]      m_data_o,
  output pps_bcast_t               bc_o,
  output pps_token_t               tok_start_o,
  input  wire pps_token_t          tok_end_i,
  input  wire logic [MaxTasks-1:0] nz_i,
  input  wire logic [MaxTasks-1:0] one_i
);

  typedef enum logic [2:0] {
    StIdle, StPrep, StScan, StRun, StFinish
  } state_e;

  state_e              state_q;
  logic [TimeW-1:0]    time_q;
  logic [CntW-1:0]     running_q;
  logic [SlotW-1:0]    pending_q;
  logic [IdW-1:0]      pend_id_q;
  logic [SwTimeW-1:0]  switch_left_q;
  logic                run_pending_q;
  logic [CountW-1:0]   sw_total_q;
  logic [CountW-1:0]   sw_ticks_q;
  logic [SwTimeW-1:0]  switch_time_q;
  logic [CntW-1:0]     task_count_q;
  logic [SlotW-1:0]    sel_q;
  logic [IdW-1:0]      sel_id_q;
  logic [TimeW-1:0]    res_tick_q;
  logic [1:0]          res_act_q;
  logic [IdW-1:0]      res_ran_q;
  logic                res_fin_q;
  logic [TimeW-1:0]    res_ft_q;
  logic                m_valid_q;
  logic [1:0]          m_user_q;
  logic [OutDataW-1:0] m_data_q;

  logic [CntW-1:0]     cnt;
  logic [MaxTasks-1:0] mask;
  logic                accept;
  logic                abandon;
  logic                pend_live;
  logic                preempt;
  logic                all_done;
  logic [TimeW-1:0]    time_inc;
  logic                out_free;

  assign cnt       = (task_count_q > CntW'(MaxTasks)) ? CntW'(MaxTasks) : task_count_q;
  assign accept    = s_valid_i && s_ready_o;
  assign s_ready_o = (state_q == StIdle);
  assign abandon   = run_pending_q &&
                     (({1'b0, pending_q} >= cnt) || !nz_i[pending_q]);
  assign pend_live = run_pending_q && !abandon;
  assign preempt   = (running_q < cnt) && (tok_end_i.slot != running_q[SlotW-1:0]) &&
                     nz_i[running_q[SlotW-1:0]];
  assign time_inc  = sat_inc(time_q);
  assign out_free  = !m_valid_q || m_ready_i;

  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      mask[i] = (CntW'(i) < cnt);
    end
  end
  assign all_done = ((nz_i & mask) == '0);

  always_comb begin
    bc_o              = '0;
    bc_o.load_we      = accept && (s_kind_i == InKindLoad);
    bc_o.load_slot    = s_data_i[3:0];
    bc_o.load_id      = s_data_i[11:4];
    bc_o.load_arrival = s_data_i[27:12];
    bc_o.load_burst   = s_data_i[43:28];
    bc_o.load_prio    = s_data_i[51:44];
    bc_o.dec_we       = (state_q == StRun);
    bc_o.dec_slot     = sel_q;
    bc_o.cnt          = cnt;
    bc_o.now          = time_q;
    tok_start_o       = '0;
    tok_start_o.live  = (state_q == StPrep) && !pend_live;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      time_q        <= '0;
      running_q     <= CntW'(MaxTasks);
      pending_q     <= '0;
      pend_id_q     <= '0;
      switch_left_q <= '0;
      run_pending_q <= 1'b0;
      sw_total_q    <= '0;
      sw_ticks_q    <= '0;
      switch_time_q <= '0;
      task_count_q  <= '0;
      sel_q         <= '0;
      sel_id_q      <= '0;
      res_tick_q    <= '0;
      res_act_q     <= ActNone;
      res_ran_q     <= '0;
      res_fin_q     <= 1'b0;
      res_ft_q      <= '0;
      m_valid_q     <= 1'b0;
      m_user_q      <= ActNone;
      m_data_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSwitchTime: switch_time_q <= cfg_data_i;
          CfgTaskCount:  task_count_q  <= cfg_data_i[CntW-1:0];
          default:       ;
        endcase
      end
      if (m_valid_q && m_ready_i && !((state_q == StFinish) && out_free)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            res_tick_q <= time_q;
            res_act_q  <= ActNone;
            res_ran_q  <= '0;
            res_fin_q  <= 1'b0;
            res_ft_q   <= '0;
            if (bc_o.load_we && (bc_o.load_slot == pending_q)) begin
              pend_id_q <= bc_o.load_id;
            end
            state_q    <= (s_kind_i == InKindTick) ? StPrep : StFinish;
          end
        end
        StPrep: begin
          if (pend_live && (switch_left_q != '0)) begin
            switch_left_q <= switch_left_q - SwTimeW'(1);
            sw_ticks_q    <= sat_inc(sw_ticks_q);
            res_act_q     <= ActSwitch;
            time_q        <= time_inc;
            state_q       <= StFinish;
          end else if (pend_live) begin
            run_pending_q <= 1'b0;
            sel_q         <= pending_q;
            sel_id_q      <= pend_id_q;
            state_q       <= StRun;
          end else begin
            run_pending_q <= 1'b0;
            switch_left_q <= '0;
            state_q       <= StScan;
          end
        end
        StScan: begin
          if (tok_end_i.live) begin
            sel_q    <= tok_end_i.slot;
            sel_id_q <= tok_end_i.id;
            if (!tok_end_i.found) begin
              res_act_q <= ActIdle;
              time_q    <= time_inc;
              state_q   <= StFinish;
            end else if (preempt) begin
              sw_total_q <= sat_inc(sw_total_q);
              if (switch_time_q != '0) begin
                pending_q     <= tok_end_i.slot;
                pend_id_q     <= tok_end_i.id;
                run_pending_q <= 1'b1;
                switch_left_q <= switch_time_q - SwTimeW'(1);
                sw_ticks_q    <= sat_inc(sw_ticks_q);
                res_act_q     <= ActSwitch;
                time_q        <= time_inc;
                state_q       <= StFinish;
              end else begin
                state_q <= StRun;
              end
            end else begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          time_q    <= time_inc;
          res_act_q <= ActRan;
          res_ran_q <= sel_id_q;
          if (one_i[sel_q]) begin
            res_fin_q <= 1'b1;
            res_ft_q  <= time_inc;
            running_q <= CntW'(MaxTasks);
          end else begin
            running_q <= {1'b0, sel_q};
          end
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_act_q;
            m_data_q  <= {6'd0, sw_ticks_q, sw_total_q, all_done, res_ft_q, res_fin_q,
                          res_ran_q, res_tick_q};
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_user_o  = m_user_q;
  assign m_data_o  = m_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load and tick transactions into the scheduler, predicts every result
// with a cycle-free scheduling model kept in the testbench, and compares each
// output transaction field by field. Directed tests cover idle ticks, priority
// and tie order, preemption with switch cost, zero bursts, field extremes and
// abandoned switches; random phases follow under changing configuration and
// random stalls on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench
  import pps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 4000;
  localparam logic [CntW-1:0] NoSlot = CntW'(MaxTasks);

  typedef struct packed {
    logic [3:0]        fill;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  arrival;
    logic [IdW-1:0]    id;
    logic [SlotW-1:0]  slot;
  } load_word_t;

  typedef struct packed {
    logic [5:0]        fill;
    logic [CountW-1:0] switch_ticks;
    logic [CountW-1:0] switch_count;
    logic              all_done;
    logic [TimeW-1:0]  finish_time;
    logic              finished;
    logic [IdW-1:0]    ran_id;
    logic [TimeW-1:0]  tick_time;
  } report_word_t;

  typedef struct packed {
    logic [1:0]   activity;
    report_word_t word;
  } sched_report_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [SwTimeW-1:0]  cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [0:0]          s_axis_tuser;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [1:0]          m_axis_tuser;
  logic [OutDataW-1:0] m_axis_tdata;

  preemptive_priority_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Scheduler state as seen by the prediction.
  logic [TimeW-1:0]   arr_tab  [MaxTasks];
  logic [BurstW-1:0]  rem_tab  [MaxTasks];
  logic [PrioW-1:0]   prio_tab [MaxTasks];
  logic [IdW-1:0]     id_tab   [MaxTasks];
  logic [TimeW-1:0]   cur_time;
  logic [CntW-1:0]    running_slot;
  logic [SlotW-1:0]   held_slot;
  logic [SwTimeW-1:0] switch_left;
  logic               switch_pending;
  logic [CountW-1:0]  switch_total;
  logic [CountW-1:0]  switch_tick_total;
  logic [SwTimeW-1:0] switch_time;
  logic [CntW-1:0]    task_count;

  sched_report_t reports_q [$];
  int            err_count;
  int            stall_pct;
  int            quiet_cycles;

  function automatic void advance_clock();
    if (cur_time != {TimeW{1'b1}}) cur_time = cur_time + 1'b1;
  endfunction

  function automatic sched_report_t schedule_item(input logic kind, input load_word_t d);
    sched_report_t r;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] sel;
    r = '0;
    r.word.tick_time = cur_time;
    r.activity = ActNone;
    cnt = (task_count > CntW'(MaxTasks)) ? CntW'(MaxTasks) : task_count;
    if (kind == InKindLoad) begin
      id_tab[d.slot]   = d.id;
      arr_tab[d.slot]  = d.arrival;
      rem_tab[d.slot]  = d.burst;
      prio_tab[d.slot] = d.prio;
    end else begin
      sel = NoSlot;
      if (switch_pending && ({1'b0, held_slot} >= cnt || rem_tab[held_slot] == 0)) begin
        switch_pending = 1'b0;
        switch_left = '0;
      end
      if (switch_pending && switch_left > 0) begin
        switch_left = switch_left - 1'b1;
        if (switch_tick_total != {CountW{1'b1}}) switch_tick_total++;
        r.activity = ActSwitch;
        advance_clock();
      end else if (switch_pending) begin
        sel = {1'b0, held_slot};
        switch_pending = 1'b0;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          if (rem_tab[i] != 0 && arr_tab[i] <= cur_time) begin
            if (sel == NoSlot || prio_tab[i] < prio_tab[sel] ||
                (prio_tab[i] == prio_tab[sel] && id_tab[i] < id_tab[sel])) begin
              sel = CntW'(i);
            end
          end
        end
        if (sel == NoSlot) begin
          r.activity = ActIdle;
          advance_clock();
        end else if (running_slot < cnt && sel != running_slot &&
                     rem_tab[running_slot] != 0) begin
          if (switch_total != {CountW{1'b1}}) switch_total++;
          if (switch_time > 0) begin
            held_slot = sel[SlotW-1:0];
            switch_pending = 1'b1;
            switch_left = switch_time - 1'b1;
            if (switch_tick_total != {CountW{1'b1}}) switch_tick_total++;
            r.activity = ActSwitch;
            advance_clock();
            sel = NoSlot;
          end
        end
      end
      if (sel < NoSlot) begin
        rem_tab[sel] = rem_tab[sel] - 1'b1;
        advance_clock();
        running_slot = sel;
        r.activity = ActRan;
        r.word.ran_id = id_tab[sel];
        if (rem_tab[sel] == 0) begin
          r.word.finished = 1'b1;
          r.word.finish_time = cur_time;
          running_slot = NoSlot;
        end
      end
    end
    r.word.all_done = 1'b1;
    for (int i = 0; i < cnt; i++) begin
      if (rem_tab[i] != 0) r.word.all_done = 1'b0;
    end
    r.word.switch_count = switch_total;
    r.word.switch_ticks = switch_tick_total;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_item(input logic kind, input load_word_t d);
    int gap;
    if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    reports_q.push_back(schedule_item(kind, d));
  endtask

  task automatic load_slot(input int slot, input int id, input int arrival,
                           input int burst, input int prio);
    load_word_t d;
    d = '0;
    d.slot    = SlotW'(slot);
    d.id      = IdW'(id);
    d.arrival = TimeW'(arrival);
    d.burst   = BurstW'(burst);
    d.prio    = PrioW'(prio);
    send_item(InKindLoad, d);
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(InKindTick, load_word_t'(0));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= SwTimeW'(value);
    @(posedge clk_i);
    if (idx == CfgSwitchTime) switch_time = SwTimeW'(value);
    else task_count = CntW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int sw_time, input int count);
    wait_drained();
    write_reg(CfgSwitchTime, sw_time);
    write_reg(CfgTaskCount, count);
  endtask

  // Consumer side: random backpressure bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_report_t exp_r;
    report_word_t  got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (reports_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual activity %0d",
                 $time, m_axis_tuser);
        err_count++;
      end else begin
        exp_r = reports_q.pop_front();
        check_field("activity", 16'(exp_r.activity), 16'(m_axis_tuser));
        check_field("tick_time", exp_r.word.tick_time, got.tick_time);
        check_field("ran_id", 16'(exp_r.word.ran_id), 16'(got.ran_id));
        check_field("finished", 16'(exp_r.word.finished), 16'(got.finished));
        check_field("finish_time", exp_r.word.finish_time, got.finish_time);
        check_field("all_done", 16'(exp_r.word.all_done), 16'(got.all_done));
        check_field("switch_count", exp_r.word.switch_count, got.switch_count);
        check_field("switch_ticks", exp_r.word.switch_ticks, got.switch_ticks);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[preemptive_priority_scheduler_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_idle_after_reset();
    tick(2);
  endtask

  task automatic test_preemption_with_cost();
    configure(2, 3);
    load_slot(0, 5, 0, 4, 9);
    load_slot(1, 3, 2, 1, 1);
    load_slot(2, 7, 0, 0, 0);
    tick(8);
  endtask

  task automatic test_tie_order();
    configure(0, 16);
    load_slot(0, 9, 0, 1, 4);
    load_slot(1, 2, 0, 1, 4);
    load_slot(2, 2, 0, 1, 4);
    tick(3);
  endtask

  task automatic test_field_extremes();
    configure(255, 31);
    load_slot(15, 255, 65535, 65535, 255);
    tick(1);
  endtask

  task automatic test_abandoned_switch();
    load_slot(0, 0, 0, 3, 200);
    tick(1);
    load_slot(1, 1, 0, 2, 0);
    tick(1);
    load_slot(1, 1, 0, 0, 0);
    tick(1);
    load_slot(1, 1, 0, 2, 0);
    tick(1);
    // The held slot falls outside the active range during the switch.
    configure(255, 1);
    tick(1);
  endtask

  task automatic test_random_mix();
    load_word_t d;
    int         cnt;
    int         a;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 4))
        0: stall_pct = 0;
        1: stall_pct = 5;
        2: stall_pct = 20;
        default: stall_pct = 45;
      endcase
      if (phase >= 10) stall_pct = 0;
      case ($urandom_range(0, 5))
        0: cnt = 0;
        1: cnt = $urandom_range(17, 31);
        2: cnt = 16;
        default: cnt = $urandom_range(1, 16);
      endcase
      if (phase == 2) a = 255;
      else if ($urandom_range(0, 5) == 0) a = $urandom_range(0, 255);
      else a = $urandom_range(0, 6);
      configure(a, cnt);
      if (cnt > 16) cnt = 16;
      for (int n = 0; n < 146; n++) begin
        d.fill    = '0;
        d.slot    = $urandom();
        d.id      = $urandom();
        d.arrival = $urandom();
        d.burst   = $urandom();
        d.prio    = $urandom();
        if ($urandom_range(0, 99) < 65) begin
          send_item(InKindTick, d);
        end else begin
          if (cnt > 0 && $urandom_range(0, 3) != 0) d.slot = $urandom_range(0, cnt - 1);
          if ($urandom_range(0, 1) == 0) d.id = $urandom_range(0, 7);
          case ($urandom_range(0, 4))
            0: d.arrival = $urandom_range(0, cur_time);
            1: ;
            default: begin
              a = cur_time + $urandom_range(0, 30);
              d.arrival = (a > 65535) ? 16'hFFFF : TimeW'(a);
            end
          endcase
          case ($urandom_range(0, 19))
            0, 1: d.burst = '0;
            2, 3: ;
            default: d.burst = $urandom_range(1, 12);
          endcase
          if ($urandom_range(0, 1) == 0) d.prio = $urandom_range(0, 3);
          d.fill = '0;
          send_item(InKindLoad, d);
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgSwitchTime;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = InKindLoad;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    err_count     = 0;
    stall_pct     = 10;
    quiet_cycles  = 0;
    for (int i = 0; i < MaxTasks; i++) begin
      arr_tab[i]  = '0;
      rem_tab[i]  = '0;
      prio_tab[i] = '0;
      id_tab[i]   = '0;
    end
    cur_time          = '0;
    running_slot      = NoSlot;
    held_slot         = '0;
    switch_left       = '0;
    switch_pending    = 1'b0;
    switch_total      = '0;
    switch_tick_total = '0;
    switch_time       = '0;
    task_count        = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_after_reset();
    test_preemption_with_cost();
    test_tie_order();
    test_field_extremes();
    test_abandoned_switch();
    test_random_mix();

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[preemptive_priority_scheduler_top] OK");
    end else begin
      $display("[preemptive_priority_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/pps_pkg.sv
src/pps_cell.sv
src/pps_ctrl.sv
src/preemptive_priority_scheduler_top.sv
tb/sv/testbench.sv
